// File: src/tlpm_pkg.sv
// Package for the tiled luma modulate block: field widths, luma weights,
// opcodes, register indexes and the item record passed from front to back.
// No dependencies.
package tlpm_pkg;

  localparam int COORD_W = 12;
  localparam int CH_W    = 8;
  localparam int DIM_W   = 9;
  localparam int OUT_W   = 16;
  localparam int LUMA_W  = 24;

  localparam int TILE_MAX_W_DEF = 256;
  localparam int TILE_MAX_H_DEF = 256;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;
  localparam logic [CH_W:0]   TILE_OFFSET = 9'd85;
  localparam logic [CH_W-1:0] TILE_CEIL   = 8'd255;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef enum logic {
    CFG_TILE_WIDTH  = 1'b0,
    CFG_TILE_HEIGHT = 1'b1
  } cfg_idx_t;

  // one classified item, tile coordinates already reduced
  typedef struct packed {
    op_t             op;
    logic            in_range;
    logic [DIM_W-1:0] tx;
    logic [DIM_W-1:0] ty;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] tval;
  } item_t;

endpackage

// File: src/tlpm_front.sv
// Front end: takes items, computes the tile value of load samples and
// reduces coordinates modulo the tile size, one quotient bit per stage.
// Depends on tlpm_pkg.
module tlpm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          stall,
  input  logic [tlpm_pkg::DIM_W-1:0]    tw,
  input  logic [tlpm_pkg::DIM_W-1:0]    th,
  input  tlpm_pkg::op_t                 op_in,
  input  logic [tlpm_pkg::COORD_W-1:0]  x_in,
  input  logic [tlpm_pkg::COORD_W-1:0]  y_in,
  input  logic [tlpm_pkg::CH_W-1:0]     red_in,
  input  logic [tlpm_pkg::CH_W-1:0]     green_in,
  input  logic [tlpm_pkg::CH_W-1:0]     blue_in,
  output logic                          push,
  output tlpm_pkg::item_t               item
);

  localparam int NSTG = tlpm_pkg::COORD_W;

  typedef struct packed {
    tlpm_pkg::item_t                    it;
    logic [tlpm_pkg::COORD_W-1:0]       xr;
    logic [tlpm_pkg::COORD_W-1:0]       yr;
  } stage_t;

  stage_t                       stg [0:NSTG];
  logic   [NSTG:0]              vld;
  logic   [tlpm_pkg::LUMA_W-1:0] lp_r;
  logic   [tlpm_pkg::LUMA_W-1:0] lp_g;
  logic   [tlpm_pkg::LUMA_W-1:0] lp_b;
  logic   [tlpm_pkg::LUMA_W:0]   lsum;
  logic   [tlpm_pkg::CH_W:0]     lbias;
  logic   [tlpm_pkg::CH_W-1:0]   tval_calc;
  stage_t                       stg0_next;

  // restoring remainder step: shift in the next coordinate bit
  function automatic logic [tlpm_pkg::DIM_W-1:0] rem_step(
    input logic [tlpm_pkg::DIM_W-1:0] rem,
    input logic                       bit_in,
    input logic [tlpm_pkg::DIM_W-1:0] dv
  );
    logic [tlpm_pkg::DIM_W:0] trial;
    trial = {rem, bit_in};
    if (trial >= {1'b0, dv}) begin
      trial = trial - {1'b0, dv};
    end
    return trial[tlpm_pkg::DIM_W-1:0];
  endfunction

  always_comb begin
    stg0_next             = '0;
    stg0_next.it.op       = op_in;
    stg0_next.it.in_range = (x_in < tlpm_pkg::COORD_W'(tw)) &&
                            (y_in < tlpm_pkg::COORD_W'(th));
    stg0_next.it.red      = red_in;
    stg0_next.it.green    = green_in;
    stg0_next.it.blue     = blue_in;
    stg0_next.xr          = x_in;
    stg0_next.yr          = y_in;
  end

  // luma: products registered with stage 0, summed and clamped into stage 1
  always_comb begin
    lsum  = (tlpm_pkg::LUMA_W+1)'(lp_r) + (tlpm_pkg::LUMA_W+1)'(lp_g) +
            (tlpm_pkg::LUMA_W+1)'(lp_b);
    lbias = {1'b0, lsum[23:16]} + tlpm_pkg::TILE_OFFSET;
    tval_calc = lbias[tlpm_pkg::CH_W] ? tlpm_pkg::TILE_CEIL : lbias[tlpm_pkg::CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (!stall) begin
      vld <= {vld[NSTG-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      stg[0] <= stg0_next;
      lp_r   <= tlpm_pkg::LUMA_W'(tlpm_pkg::LUMA_WR * red_in);
      lp_g   <= tlpm_pkg::LUMA_W'(tlpm_pkg::LUMA_WG * green_in);
      lp_b   <= tlpm_pkg::LUMA_W'(tlpm_pkg::LUMA_WB * blue_in);
      for (int k = 1; k <= NSTG; k++) begin
        stg[k].it.op       <= stg[k-1].it.op;
        stg[k].it.in_range <= stg[k-1].it.in_range;
        stg[k].it.red      <= stg[k-1].it.red;
        stg[k].it.green    <= stg[k-1].it.green;
        stg[k].it.blue     <= stg[k-1].it.blue;
        stg[k].it.tx       <= rem_step(stg[k-1].it.tx, stg[k-1].xr[NSTG-1], tw);
        stg[k].it.ty       <= rem_step(stg[k-1].it.ty, stg[k-1].yr[NSTG-1], th);
        stg[k].xr          <= {stg[k-1].xr[NSTG-2:0], 1'b0};
        stg[k].yr          <= {stg[k-1].yr[NSTG-2:0], 1'b0};
        stg[k].it.tval     <= (k == 1) ? tval_calc : stg[k-1].it.tval;
      end
    end
  end

  assign push = vld[NSTG] && !stall;
  assign item = stg[NSTG].it;

endmodule

// File: src/tlpm_queue.sv
// Small FIFO that decouples the front end from the tile store side.
// Depends on tlpm_pkg.
module tlpm_queue #(
  parameter int DEPTH = tlpm_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlpm_pkg::item_t wr_item,
  input  logic            pop,
  output tlpm_pkg::item_t rd_item,
  output logic            empty,
  output logic            full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tlpm_pkg::item_t mem [0:DEPTH-1];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

// File: src/tlpm_back.sv
// Back end: owns the tile store, writes loads, reads for renders and
// multiplies each channel by the tile value. Depends on tlpm_pkg.
module tlpm_back #(
  parameter int TILE_MAX_W = tlpm_pkg::TILE_MAX_W_DEF,
  parameter int TILE_MAX_H = tlpm_pkg::TILE_MAX_H_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  tlpm_pkg::item_t             q_item,
  output logic                        pop,
  output logic                        done,
  output logic [tlpm_pkg::OUT_W-1:0]  out_red,
  output logic [tlpm_pkg::OUT_W-1:0]  out_green,
  output logic [tlpm_pkg::OUT_W-1:0]  out_blue
);

  localparam int DEPTH = TILE_MAX_W * TILE_MAX_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [tlpm_pkg::CH_W-1:0] store [0:DEPTH-1];
  logic [AW-1:0]             addr;
  logic                      wr_en;
  logic                      rd_vld;
  logic [tlpm_pkg::CH_W-1:0] rd_data;
  logic [tlpm_pkg::CH_W-1:0] r1;
  logic [tlpm_pkg::CH_W-1:0] g1;
  logic [tlpm_pkg::CH_W-1:0] b1;

  assign pop   = !q_empty;
  assign addr  = AW'(AW'(q_item.ty) * AW'(TILE_MAX_W)) + AW'(q_item.tx);
  assign wr_en = pop && (q_item.op == tlpm_pkg::OP_LOAD) && q_item.in_range;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[addr] <= q_item.tval;
    end
    rd_data <= store[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      rd_vld <= pop && (q_item.op == tlpm_pkg::OP_RENDER);
      done   <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    r1        <= q_item.red;
    g1        <= q_item.green;
    b1        <= q_item.blue;
    out_red   <= r1 * rd_data;
    out_green <= g1 * rd_data;
    out_blue  <= b1 * rd_data;
  end

endmodule

// File: src/tiled_luma_poster_modulate.sv
// Top level of the tiled luma modulate block: config registers, front end,
// queue and tile store back end. Depends on tlpm_pkg, tlpm_front,
// tlpm_queue and tlpm_back.
//
// Takes one item per clock while busy is low; a render gives one result on
// out_red/out_green/out_blue with done high for a single cycle, after the
// 12-stage coordinate remainder pipeline, the queue, the tile store read and
// the multiply. Loads give no result. The receiver cannot stall; done is not
// held. The tile store has no reset: render only tile entries that were
// loaded. Write tile_width/tile_height only while no item is in flight.
module tiled_luma_poster_modulate #(
  parameter int TILE_MAX_W = tlpm_pkg::TILE_MAX_W_DEF,
  parameter int TILE_MAX_H = tlpm_pkg::TILE_MAX_H_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [tlpm_pkg::DIM_W-1:0]    wr_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [tlpm_pkg::COORD_W-1:0]  x,
  input  logic [tlpm_pkg::COORD_W-1:0]  y,
  input  logic [tlpm_pkg::CH_W-1:0]     red,
  input  logic [tlpm_pkg::CH_W-1:0]     green,
  input  logic [tlpm_pkg::CH_W-1:0]     blue,
  output logic                          done,
  output logic [tlpm_pkg::OUT_W-1:0]    out_red,
  output logic [tlpm_pkg::OUT_W-1:0]    out_green,
  output logic [tlpm_pkg::OUT_W-1:0]    out_blue
);

  logic [tlpm_pkg::DIM_W-1:0] tile_width;
  logic [tlpm_pkg::DIM_W-1:0] tile_height;
  logic [tlpm_pkg::DIM_W-1:0] tw_eff;
  logic [tlpm_pkg::DIM_W-1:0] th_eff;
  logic                       accept;
  logic                       q_full;
  logic                       q_empty;
  logic                       push;
  logic                       pop;
  tlpm_pkg::item_t            f_item;
  tlpm_pkg::item_t            q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width  <= tlpm_pkg::DIM_W'(1);
      tile_height <= tlpm_pkg::DIM_W'(1);
    end else if (wr_en) begin
      case (tlpm_pkg::cfg_idx_t'(wr_index))
        tlpm_pkg::CFG_TILE_WIDTH:  tile_width  <= wr_data;
        tlpm_pkg::CFG_TILE_HEIGHT: tile_height <= wr_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the store's limit
  always_comb begin
    tw_eff = tile_width;
    if (tile_width == '0) begin
      tw_eff = tlpm_pkg::DIM_W'(1);
    end else if (32'(tile_width) > TILE_MAX_W) begin
      tw_eff = tlpm_pkg::DIM_W'(TILE_MAX_W);
    end
    th_eff = tile_height;
    if (tile_height == '0) begin
      th_eff = tlpm_pkg::DIM_W'(1);
    end else if (32'(tile_height) > TILE_MAX_H) begin
      th_eff = tlpm_pkg::DIM_W'(TILE_MAX_H);
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  tlpm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .stall    (q_full),
    .tw       (tw_eff),
    .th       (th_eff),
    .op_in    (tlpm_pkg::op_t'(operation)),
    .x_in     (x),
    .y_in     (y),
    .red_in   (red),
    .green_in (green),
    .blue_in  (blue),
    .push     (push),
    .item     (f_item)
  );

  tlpm_queue #(
    .DEPTH (tlpm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (f_item),
    .pop     (pop),
    .rd_item (q_item),
    .empty   (q_empty),
    .full    (q_full)
  );

  tlpm_back #(
    .TILE_MAX_W (TILE_MAX_W),
    .TILE_MAX_H (TILE_MAX_H)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .pop       (pop),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

// File: test/tlpm_checker.sv
// Checker for tiled_luma_poster_modulate: watches the config port, the item
// transaction and the result strobe, predicts each render and compares.
// Depends on tlpm_pkg.
module tlpm_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [tlpm_pkg::DIM_W-1:0]    wr_data,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          operation,
  input  logic [tlpm_pkg::COORD_W-1:0]  x,
  input  logic [tlpm_pkg::COORD_W-1:0]  y,
  input  logic [tlpm_pkg::CH_W-1:0]     red,
  input  logic [tlpm_pkg::CH_W-1:0]     green,
  input  logic [tlpm_pkg::CH_W-1:0]     blue,
  input  logic                          done,
  input  logic [tlpm_pkg::OUT_W-1:0]    out_red,
  input  logic [tlpm_pkg::OUT_W-1:0]    out_green,
  input  logic [tlpm_pkg::OUT_W-1:0]    out_blue,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlpm_pkg::*;

  localparam int SPAN_W = TILE_MAX_W_DEF;
  localparam int SPAN_H = TILE_MAX_H_DEF;

  typedef struct {
    logic [OUT_W-1:0] ch [3];
  } pixel_t;

  pixel_t           pixel_q [$];
  logic [CH_W-1:0]  tile_mem [0:SPAN_W*SPAN_H-1];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  // zero acts as one, oversize saturates at the store span
  function automatic int unsigned fold_dim(logic [DIM_W-1:0] v, int unsigned span);
    if (v == 0) return 1;
    if (v > span) return span;
    return v;
  endfunction

  function automatic logic [CH_W-1:0] tile_level(int unsigned r, int unsigned g,
                                                 int unsigned b);
    int unsigned luma;
    luma = (LUMA_WR * r + LUMA_WG * g + LUMA_WB * b) >> 16;
    luma = luma + TILE_OFFSET;
    if (luma > TILE_CEIL) luma = TILE_CEIL;
    return luma[CH_W-1:0];
  endfunction

  always @(posedge clk) begin
    pixel_t          want;
    pixel_t          got;
    int unsigned     ew;
    int unsigned     eh;
    int unsigned     lvl;
    string           names [3];
    names = '{"out_red", "out_green", "out_blue"};
    if (rst) begin
      pixel_q.delete();
      width_reg  = 1;
      height_reg = 1;
      fail_count = 0;
    end else begin
      if (done) begin
        got.ch = '{out_red, out_green, out_blue};
        if (pixel_q.size() == 0) begin
          $display("%0t: result with no render pending: %0d %0d %0d",
                   $time, out_red, out_green, out_blue);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got.ch[i] !== want.ch[i]) begin
              $display("%0t: %s expected %0d, actual %0d",
                       $time, names[i], want.ch[i], got.ch[i]);
              fail_count++;
            end
          end
        end
      end
      if (wr_en) begin
        if (wr_index == CFG_TILE_WIDTH) width_reg = wr_data;
        else height_reg = wr_data;
      end
      if (start && !busy) begin
        ew = fold_dim(width_reg, SPAN_W);
        eh = fold_dim(height_reg, SPAN_H);
        if (op_t'(operation) == OP_LOAD) begin
          // out-of-tile loads leave the store untouched
          if (x < ew && y < eh) tile_mem[y * SPAN_W + x] = tile_level(red, green, blue);
        end else begin
          lvl = tile_mem[(y % eh) * SPAN_W + (x % ew)];
          want.ch[0] = red * lvl;
          want.ch[1] = green * lvl;
          want.ch[2] = blue * lvl;
          pixel_q.push_back(want);
        end
      end
    end
    pending = pixel_q.size();
  end

endmodule

// File: test/tb.sv
// Testbench top for tiled_luma_poster_modulate: clock, reset, tile size
// phases and load/render stimulus; checking is done by tlpm_checker.
// Depends on tlpm_pkg, tlpm_checker and the block itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlpm_pkg::*;

  localparam int SPAN_W        = TILE_MAX_W_DEF;
  localparam int SPAN_H        = TILE_MAX_H_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_CAP     = 2000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 130;

  logic                clk = 1'b0;
  logic                rst;
  logic                wr_en;
  logic                wr_index;
  logic [DIM_W-1:0]    wr_data;
  logic                start;
  logic                busy;
  logic                operation;
  logic [COORD_W-1:0]  x;
  logic [COORD_W-1:0]  y;
  logic [CH_W-1:0]     red;
  logic [CH_W-1:0]     green;
  logic [CH_W-1:0]     blue;
  logic                done;
  logic [OUT_W-1:0]    out_red;
  logic [OUT_W-1:0]    out_green;
  logic [OUT_W-1:0]    out_blue;
  int                  fail_count;
  int                  pending;

  // tile entries loaded since reset; renders only touch these
  bit                  loaded [0:SPAN_W*SPAN_H-1];
  int unsigned         eff_w = 1;
  int unsigned         eff_h = 1;
  int unsigned         idle_pct = 0;

  tiled_luma_poster_modulate dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .start(start), .busy(busy), .operation(operation), .x(x), .y(y),
    .red(red), .green(green), .blue(blue), .done(done),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  tlpm_checker chk (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .start(start), .busy(busy), .operation(operation), .x(x), .y(y),
    .red(red), .green(green), .blue(blue), .done(done),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned pick_channel();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // one item transaction, with random sender gaps ahead of it
  task automatic drive_item(input op_t op, input int unsigned xi, input int unsigned yi,
                            input int unsigned r, input int unsigned g,
                            input int unsigned b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start     <= 1'b1;
    operation <= op;
    x         <= xi[COORD_W-1:0];
    y         <= yi[COORD_W-1:0];
    red       <= r[CH_W-1:0];
    green     <= g[CH_W-1:0];
    blue      <= b[CH_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_LOAD && xi < eff_w && yi < eff_h) loaded[yi * SPAN_W + xi] = 1'b1;
  endtask

  // render anywhere in the image; load the tile entry first if it is still blank
  task automatic render_any(input int unsigned xi, input int unsigned yi);
    int unsigned tx;
    int unsigned ty;
    tx = xi % eff_w;
    ty = yi % eff_h;
    if (!loaded[ty * SPAN_W + tx])
      drive_item(OP_LOAD, tx, ty, pick_channel(), pick_channel(), pick_channel());
    drive_item(OP_RENDER, xi, yi, pick_channel(), pick_channel(), pick_channel());
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 && waited < DRAIN_CAP) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_tile(input int unsigned w, input int unsigned h);
    settle();
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= CFG_TILE_WIDTH;
    wr_data  <= w[DIM_W-1:0];
    @(negedge clk);
    wr_index <= CFG_TILE_HEIGHT;
    wr_data  <= h[DIM_W-1:0];
    @(negedge clk);
    wr_en    <= 1'b0;
    eff_w = (w == 0) ? 1 : (w > SPAN_W ? SPAN_W : w);
    eff_h = (h == 0) ? 1 : (h > SPAN_H ? SPAN_H : h);
  endtask

  initial begin
    int unsigned pw [PHASES];
    int unsigned ph [PHASES];
    int unsigned roll;
    pw = '{1, 256, 1, 511, 256, 3, 257, 0, 0, 0, 0, 0};
    ph = '{1, 1, 256, 0, 256, 5, 7, 0, 0, 0, 0, 0};
    rst       = 1'b1;
    wr_en     = 1'b0;
    wr_index  = 1'b0;
    wr_data   = '0;
    start     = 1'b0;
    operation = 1'b0;
    x         = '0;
    y         = '0;
    red       = '0;
    green     = '0;
    blue      = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset tile is 1x1: levels at the floor, at the ceiling and just past it
    drive_item(OP_LOAD, 0, 0, 0, 0, 0);
    drive_item(OP_RENDER, 0, 0, 255, 255, 255);
    drive_item(OP_RENDER, 4095, 4095, 0, 128, 1);
    drive_item(OP_LOAD, 1, 0, 255, 255, 255);
    drive_item(OP_LOAD, 0, 4095, 255, 255, 255);
    drive_item(OP_RENDER, 7, 9, 255, 0, 0);
    drive_item(OP_LOAD, 0, 0, 255, 255, 255);
    drive_item(OP_RENDER, 4095, 0, 255, 255, 255);
    drive_item(OP_LOAD, 0, 0, 170, 170, 170);
    drive_item(OP_RENDER, 1, 2, 0, 255, 0);
    drive_item(OP_LOAD, 0, 0, 171, 171, 171);
    drive_item(OP_RENDER, 2048, 1024, 0, 0, 255);
    drive_item(OP_LOAD, 0, 0, 1, 1, 1);
    drive_item(OP_RENDER, 0, 4095, 3, 200, 17);
    drive_item(OP_LOAD, 0, 0, 0, 0, 1);
    drive_item(OP_RENDER, 2730, 1365, 255, 255, 255);

    // zero sizes act as one; entries keep their places
    set_tile(0, 0);
    drive_item(OP_RENDER, 3333, 77, 128, 64, 32);

    // oversize saturates to the full store
    set_tile(511, 511);
    drive_item(OP_LOAD, 255, 255, 90, 200, 45);
    drive_item(OP_RENDER, 4095, 4095, 255, 1, 254);
    drive_item(OP_LOAD, 256, 0, 0, 0, 0);
    drive_item(OP_LOAD, 0, 256, 0, 0, 0);
    drive_item(OP_RENDER, 255, 511, 10, 20, 30);

    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES / 3) idle_pct = 28;
      else if (p < 2 * PHASES / 3) idle_pct = 53;
      else idle_pct = 0;
      if (p >= 7) begin
        pw[p] = $urandom_range(1, 20);
        ph[p] = $urandom_range(1, 20);
      end
      set_tile(pw[p], ph[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(99);
        if (roll < 65) begin
          render_any($urandom_range(4095), $urandom_range(4095));
        end else if (roll < 88) begin
          drive_item(OP_LOAD, $urandom_range(eff_w - 1), $urandom_range(eff_h - 1),
                     pick_channel(), pick_channel(), pick_channel());
        end else if ($urandom_range(1)) begin
          drive_item(OP_LOAD, $urandom_range(4095, eff_w), $urandom_range(4095),
                     pick_channel(), pick_channel(), pick_channel());
        end else begin
          drive_item(OP_LOAD, $urandom_range(4095), $urandom_range(4095, eff_h),
                     pick_channel(), pick_channel(), pick_channel());
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/tlpm_pkg.sv
src/tlpm_front.sv
src/tlpm_queue.sv
src/tlpm_back.sv
src/tiled_luma_poster_modulate.sv
test/tlpm_checker.sv
test/tb.sv
